FILE: rtl/core/vertex_dedup_index_remap_unit_defines.svh
// Assertion macros shared by the vertex dedup and remap unit.
`ifndef VERTEX_DEDUP_INDEX_REMAP_UNIT_DEFINES_SVH
`define VERTEX_DEDUP_INDEX_REMAP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define VDR_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("vdr assertion failed");
`define VDR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("vdr assertion failed");
`else
`define VDR_ASSERT_IMPLIES(lbl, pre, post)
`define VDR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/core/vdr_pkg.sv
// Types, constants and the key hash of the vertex dedup and remap unit.
`timescale 1ns / 1ps
package vdr_pkg;

  localparam int MAX_VERTICES    = 1024;
  localparam int ATTR_INDEX_BITS = 16;
  localparam int SLOT_BITS       = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS      = SLOT_BITS + 1;
  localparam int HASH_BITS       = SLOT_BITS + 1;
  localparam int HASH_DEPTH      = 2 * MAX_VERTICES;
  localparam int KEY_BITS        = 3 * ATTR_INDEX_BITS;
  localparam int EPOCH_BITS      = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_VERTICES);

  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_LOAD  = 2'd1;
  localparam logic [1:0] OPC_REMAP = 2'd2;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_LOAD,
    CMD_REMAP,
    CMD_NONE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [KEY_BITS-1:0]    key;
    logic [SLOT_BITS-1:0]   old_index;
    logic [HASH_BITS-1:0]   hash;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]  new_index;
    logic                  is_new;
    logic [COUNT_BITS-1:0] distinct_count;
    status_t               status;
  } res_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic [HASH_BITS-1:0] hash_key(input logic [KEY_BITS-1:0] key);
    logic [HASH_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      h[i % HASH_BITS] = h[i % HASH_BITS] ^ key[i];
    end
    return h;
  endfunction

endpackage

FILE: rtl/core/vertex_dedup_index_remap_unit.sv
// Requests pass the front register and command queue to a back end that serves one at a time.
// A load probes the hash table, P = hash probes (1 when no collision); a remap reads the
// redirection table; then the result register is filled. The queue takes requests meanwhile.
// Reset is synchronous and active low; afterward a pass clears the hash table
// and no request is accepted until it ends. Every 15th start repeats that pass.
`timescale 1ns / 1ps
module vertex_dedup_index_remap_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_position_index,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_normal_index,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_uv_index,
  input  logic [vdr_pkg::SLOT_BITS-1:0]       in_old_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vdr_pkg::SLOT_BITS-1:0]       out_new_index,
  output logic                                out_is_new,
  output logic [vdr_pkg::COUNT_BITS-1:0]      out_distinct_count,
  output logic [1:0]                          out_status
);

  vdr_pkg::back_stat_t stat;
  logic                f_valid;
  logic                f_ready;
  vdr_pkg::cmd_t       f_cmd;
  logic                q_valid;
  logic                q_ready;
  vdr_pkg::cmd_t       q_cmd;

  vdr_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_position_index(in_position_index),
    .in_normal_index  (in_normal_index),
    .in_uv_index      (in_uv_index),
    .in_old_index     (in_old_index),
    .stat             (stat),
    .cmd_valid        (f_valid),
    .cmd_ready        (f_ready),
    .cmd              (f_cmd)
  );

  vdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_cmd  (f_cmd),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_cmd   (q_cmd)
  );

  vdr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_cmd             (q_cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_index     (out_new_index),
    .out_is_new        (out_is_new),
    .out_distinct_count(out_distinct_count),
    .out_status        (out_status)
  );

endmodule

FILE: rtl/core/vdr_front.sv
// Front end: accepts requests, classifies them and hashes the vertex key.
`timescale 1ns / 1ps
module vdr_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_opcode,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_position_index,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_normal_index,
  input  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_uv_index,
  input  logic [vdr_pkg::SLOT_BITS-1:0]     in_old_index,
  input  vdr_pkg::back_stat_t               stat,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output vdr_pkg::cmd_t                     cmd
);

  logic          f_valid_r;
  vdr_pkg::cmd_t f_cmd_r;
  vdr_pkg::cmd_t cls;

  always_comb begin
    cls.key       = {in_position_index, in_normal_index, in_uv_index};
    cls.old_index = in_old_index;
    cls.hash      = vdr_pkg::hash_key(cls.key);
    case (in_opcode)
      vdr_pkg::OPC_START: cls.kind = vdr_pkg::CMD_START;
      vdr_pkg::OPC_LOAD:  cls.kind = vdr_pkg::CMD_LOAD;
      vdr_pkg::OPC_REMAP: cls.kind = vdr_pkg::CMD_REMAP;
      default:            cls.kind = vdr_pkg::CMD_NONE;
    endcase
  end

  assign in_ready  = !stat.clearing && (!f_valid_r || cmd_ready);
  assign cmd_valid = f_valid_r;
  assign cmd       = f_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid_r <= 1'b1;
    end else if (cmd_ready) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd_r <= cls;
    end
  end

endmodule

FILE: rtl/core/vdr_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module vdr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  vdr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output vdr_pkg::cmd_t pop_cmd
);

  vdr_pkg::cmd_t                   q_r [vdr_pkg::QUEUE_DEPTH];
  logic [vdr_pkg::QPTR_BITS-1:0]   wr_ptr_r;
  logic [vdr_pkg::QPTR_BITS-1:0]   rd_ptr_r;
  logic [vdr_pkg::QPTR_BITS:0]     count_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = count_r != (vdr_pkg::QPTR_BITS + 1)'(vdr_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/vdr_back.sv
// Back end: hash table probe and insert, redirection table and result register.
`timescale 1ns / 1ps
`include "vertex_dedup_index_remap_unit_defines.svh"
module vdr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  vdr_pkg::cmd_t                     q_cmd,
  output vdr_pkg::back_stat_t               stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vdr_pkg::SLOT_BITS-1:0]     out_new_index,
  output logic                              out_is_new,
  output logic [vdr_pkg::COUNT_BITS-1:0]    out_distinct_count,
  output logic [1:0]                        out_status
);

  typedef struct packed {
    logic [vdr_pkg::EPOCH_BITS-1:0] epoch;
    logic [vdr_pkg::KEY_BITS-1:0]   key;
    logic [vdr_pkg::SLOT_BITS-1:0]  slot;
  } ht_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_REMAP,
    S_RESULT
  } state_t;

  ht_entry_t                        ht_mem [vdr_pkg::HASH_DEPTH];
  logic [vdr_pkg::SLOT_BITS-1:0]    rd_mem [vdr_pkg::MAX_VERTICES];

  state_t                           state_r;
  logic [vdr_pkg::EPOCH_BITS-1:0]   epoch_r;
  logic [vdr_pkg::HASH_BITS-1:0]    clr_addr_r;
  logic [vdr_pkg::HASH_BITS-1:0]    probe_addr_r;
  logic [vdr_pkg::KEY_BITS-1:0]     key_r;
  logic [vdr_pkg::COUNT_BITS-1:0]   loaded_r;
  logic [vdr_pkg::COUNT_BITS-1:0]   slot_cnt_r;
  logic                             res_pend_r;
  vdr_pkg::res_t                    res_r;
  vdr_pkg::res_t                    out_r;
  logic                             out_valid_r;
  ht_entry_t                        ht_rdata_r;
  logic [vdr_pkg::SLOT_BITS-1:0]    rd_rdata_r;

  state_t                           state_nxt;
  logic [vdr_pkg::EPOCH_BITS-1:0]   epoch_nxt;
  logic [vdr_pkg::HASH_BITS-1:0]    clr_addr_nxt;
  logic [vdr_pkg::HASH_BITS-1:0]    probe_addr_nxt;
  logic [vdr_pkg::KEY_BITS-1:0]     key_nxt;
  logic [vdr_pkg::COUNT_BITS-1:0]   loaded_nxt;
  logic [vdr_pkg::COUNT_BITS-1:0]   slot_cnt_nxt;
  logic                             res_pend_nxt;
  vdr_pkg::res_t                    res_nxt;
  vdr_pkg::res_t                    out_nxt;
  logic                             out_valid_nxt;

  logic [vdr_pkg::HASH_BITS-1:0]    ht_raddr;
  logic                             ht_we;
  logic [vdr_pkg::HASH_BITS-1:0]    ht_waddr;
  ht_entry_t                        ht_wdata;
  logic                             rd_we;
  logic [vdr_pkg::SLOT_BITS-1:0]    rd_wdata;
  logic                             entry_empty;
  logic                             entry_hit;
  logic                             do_insert;
  logic                             out_free;

  assign entry_empty = ht_rdata_r.epoch != epoch_r;
  assign entry_hit   = !entry_empty && (ht_rdata_r.key == key_r);
  assign do_insert   = (state_r == S_PROBE) && entry_empty;
  assign out_free    = !out_valid_r || out_ready;
  assign q_ready     = state_r == S_IDLE;
  assign stat.clearing = state_r == S_CLEAR;

  assign ht_raddr = (state_r == S_IDLE) ? q_cmd.hash : probe_addr_r + 1'b1;

  always_comb begin
    ht_we    = 1'b0;
    ht_waddr = probe_addr_r;
    ht_wdata = '{epoch: epoch_r, key: key_r, slot: slot_cnt_r[vdr_pkg::SLOT_BITS-1:0]};
    rd_we    = 1'b0;
    rd_wdata = slot_cnt_r[vdr_pkg::SLOT_BITS-1:0];
    case (state_r)
      S_CLEAR: begin
        ht_we    = 1'b1;
        ht_waddr = clr_addr_r;
        ht_wdata = '{epoch: '0, key: '0, slot: '0};
      end
      S_PROBE: begin
        if (entry_empty) begin
          ht_we = 1'b1;
          rd_we = 1'b1;
        end else if (entry_hit) begin
          rd_we    = 1'b1;
          rd_wdata = ht_rdata_r.slot;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ht_rdata_r <= ht_mem[ht_raddr];
    if (ht_we) begin
      ht_mem[ht_waddr] <= ht_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_rdata_r <= rd_mem[q_cmd.old_index];
    if (rd_we) begin
      rd_mem[loaded_r[vdr_pkg::SLOT_BITS-1:0]] <= rd_wdata;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    epoch_nxt      = epoch_r;
    clr_addr_nxt   = clr_addr_r;
    probe_addr_nxt = probe_addr_r;
    key_nxt        = key_r;
    loaded_nxt     = loaded_r;
    slot_cnt_nxt   = slot_cnt_r;
    res_pend_nxt   = res_pend_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = res_pend_r ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          key_nxt        = q_cmd.key;
          probe_addr_nxt = q_cmd.hash;
          res_nxt        = '{new_index: '0, is_new: 1'b0, distinct_count: slot_cnt_r,
                             status: vdr_pkg::ST_OK};
          state_nxt      = S_RESULT;
          case (q_cmd.kind)
            vdr_pkg::CMD_START: begin
              loaded_nxt             = '0;
              slot_cnt_nxt           = '0;
              res_nxt.distinct_count = '0;
              if (epoch_r == '1) begin
                epoch_nxt    = vdr_pkg::EPOCH_BITS'(1);
                clr_addr_nxt = '0;
                res_pend_nxt = 1'b1;
                state_nxt    = S_CLEAR;
              end else begin
                epoch_nxt = epoch_r + 1'b1;
              end
            end
            vdr_pkg::CMD_LOAD: begin
              if (loaded_r >= vdr_pkg::MAX_COUNT) begin
                res_nxt.status = vdr_pkg::ST_FULL;
              end else begin
                state_nxt = S_PROBE;
              end
            end
            vdr_pkg::CMD_REMAP: begin
              if (vdr_pkg::COUNT_BITS'(q_cmd.old_index) >= loaded_r) begin
                res_nxt.status = vdr_pkg::ST_NOT_LOADED;
              end else begin
                state_nxt = S_REMAP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        if (do_insert) begin
          res_nxt.new_index      = slot_cnt_r[vdr_pkg::SLOT_BITS-1:0];
          res_nxt.is_new         = 1'b1;
          res_nxt.distinct_count = slot_cnt_r + 1'b1;
          slot_cnt_nxt           = slot_cnt_r + 1'b1;
          loaded_nxt             = loaded_r + 1'b1;
          state_nxt              = S_RESULT;
        end else if (entry_hit) begin
          res_nxt.new_index = ht_rdata_r.slot;
          loaded_nxt        = loaded_r + 1'b1;
          state_nxt         = S_RESULT;
        end else begin
          probe_addr_nxt = probe_addr_r + 1'b1;
        end
      end
      S_REMAP: begin
        res_nxt.new_index = rd_rdata_r;
        state_nxt         = S_RESULT;
      end
      S_RESULT: begin
        res_pend_nxt = 1'b0;
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      epoch_r     <= vdr_pkg::EPOCH_BITS'(1);
      clr_addr_r  <= '0;
      loaded_r    <= '0;
      slot_cnt_r  <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      clr_addr_r   <= clr_addr_nxt;
      probe_addr_r <= probe_addr_nxt;
      key_r        <= key_nxt;
      loaded_r     <= loaded_nxt;
      slot_cnt_r   <= slot_cnt_nxt;
      res_pend_r   <= res_pend_nxt;
      res_r        <= res_nxt;
      out_r        <= out_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_index      = out_r.new_index;
  assign out_is_new         = out_r.is_new;
  assign out_distinct_count = out_r.distinct_count;
  assign out_status         = out_r.status;

  `VDR_ASSERT_IMPLIES(a_slot_bound, 1'b1, slot_cnt_r <= loaded_r)
  `VDR_ASSERT_IMPLIES(a_loaded_max, 1'b1, loaded_r <= vdr_pkg::MAX_COUNT)
  `VDR_ASSERT_NEXT(a_insert_count, do_insert, slot_cnt_r == $past(slot_cnt_r) + 1'b1)
  `VDR_ASSERT_IMPLIES(a_no_pop_clear, state_r == S_CLEAR, !q_ready)

endmodule

FILE: bench/tb_vertex_dedup_index_remap_unit.sv
// Self-checking testbench for the vertex dedup and index remap unit.
`timescale 1ns / 1ps
module tb_vertex_dedup_index_remap_unit;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 12000;

  typedef struct {
    logic [vdr_pkg::SLOT_BITS-1:0]  new_index;
    logic                           is_new;
    logic [vdr_pkg::COUNT_BITS-1:0] distinct_count;
    vdr_pkg::status_t               status;
  } remap_result_t;

  typedef struct {
    logic [1:0]                          op;
    logic [vdr_pkg::ATTR_INDEX_BITS-1:0] pos;
    logic [vdr_pkg::ATTR_INDEX_BITS-1:0] nrm;
    logic [vdr_pkg::ATTR_INDEX_BITS-1:0] uv;
    logic [vdr_pkg::SLOT_BITS-1:0]       old;
    bit                                  typed;
    remap_result_t                       res;
  } request_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_opcode;
  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_position_index;
  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_normal_index;
  logic [vdr_pkg::ATTR_INDEX_BITS-1:0] in_uv_index;
  logic [vdr_pkg::SLOT_BITS-1:0] in_old_index;
  logic out_valid;
  logic out_ready;
  logic [vdr_pkg::SLOT_BITS-1:0] out_new_index;
  logic out_is_new;
  logic [vdr_pkg::COUNT_BITS-1:0] out_distinct_count;
  logic [1:0] out_status;

  logic [vdr_pkg::KEY_BITS-1:0]   weld_keys [vdr_pkg::MAX_VERTICES];
  logic [vdr_pkg::SLOT_BITS-1:0]  corner_slot [vdr_pkg::MAX_VERTICES];
  int                             loaded_verts;
  int                             distinct_verts;
  remap_result_t                  pending_results[$];
  request_t                       announced_q[$];
  int                             errors;
  int                             idle_cycles;
  bit                             hold_req;
  int                             burst_left;
  logic [vdr_pkg::KEY_BITS-1:0]   key_pool [8];

  vertex_dedup_index_remap_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic remap_result_t mk(int idx, bit fresh, int cnt, vdr_pkg::status_t st);
    remap_result_t r;
    r.new_index = idx[vdr_pkg::SLOT_BITS-1:0];
    r.is_new = fresh;
    r.distinct_count = cnt[vdr_pkg::COUNT_BITS-1:0];
    r.status = st;
    return r;
  endfunction

  function automatic remap_result_t weld_predict(request_t q);
    logic [vdr_pkg::KEY_BITS-1:0] k;
    int slot;
    k = {q.pos, q.nrm, q.uv};
    slot = -1;
    case (q.op)
      vdr_pkg::OPC_START: begin
        loaded_verts = 0;
        distinct_verts = 0;
        return mk(0, 0, 0, vdr_pkg::ST_OK);
      end
      vdr_pkg::OPC_LOAD: begin
        if (loaded_verts >= vdr_pkg::MAX_VERTICES) begin
          return mk(0, 0, distinct_verts, vdr_pkg::ST_FULL);
        end
        for (int s = 0; s < distinct_verts; s++) begin
          if (slot < 0 && weld_keys[vdr_pkg::SLOT_BITS'(s)] == k) slot = s;
        end
        corner_slot[vdr_pkg::SLOT_BITS'(loaded_verts)] =
          vdr_pkg::SLOT_BITS'((slot < 0) ? distinct_verts : slot);
        loaded_verts++;
        if (slot < 0) begin
          weld_keys[vdr_pkg::SLOT_BITS'(distinct_verts)] = k;
          distinct_verts++;
          return mk(distinct_verts - 1, 1, distinct_verts, vdr_pkg::ST_OK);
        end
        return mk(slot, 0, distinct_verts, vdr_pkg::ST_OK);
      end
      vdr_pkg::OPC_REMAP: begin
        if (int'(q.old) >= loaded_verts) begin
          return mk(0, 0, distinct_verts, vdr_pkg::ST_NOT_LOADED);
        end
        return mk(int'(corner_slot[q.old]), 0, distinct_verts, vdr_pkg::ST_OK);
      end
      default: return mk(0, 0, distinct_verts, vdr_pkg::ST_OK);
    endcase
  endfunction

  // Predictions are made as each request is accepted; results are checked in order.
  always @(posedge clk) begin
    remap_result_t p;
    remap_result_t e;
    request_t q;
    if (rst_n && in_valid && in_ready) begin
      q = announced_q.pop_front();
      p = weld_predict(q);
      if (q.typed) p = q.res;
      pending_results = {pending_results, p};
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result new_index %0d", $time, out_new_index);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_new_index !== e.new_index || out_is_new !== e.is_new ||
            out_distinct_count !== e.distinct_count || out_status !== e.status) begin
          $display("%0t: expected idx %0d new %0d cnt %0d st %0d, got %0d %0d %0d %0d",
                   $time, e.new_index, e.is_new, e.distinct_count, e.status,
                   out_new_index, out_is_new, out_distinct_count, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver cycles through stall patterns and takes one long hold on request.
  initial begin
    int mode;
    mode = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else begin
        if ($urandom_range(0, 150) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send(request_t q);
    announced_q = {announced_q, q};
    in_valid <= 1'b1;
    in_opcode <= q.op;
    in_position_index <= q.pos;
    in_normal_index <= q.nrm;
    in_uv_index <= q.uv;
    in_old_index <= q.old;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  function automatic request_t req(logic [1:0] op, int p, int n, int u, int o);
    request_t q;
    q.op = op;
    q.pos = p[vdr_pkg::ATTR_INDEX_BITS-1:0];
    q.nrm = n[vdr_pkg::ATTR_INDEX_BITS-1:0];
    q.uv = u[vdr_pkg::ATTR_INDEX_BITS-1:0];
    q.old = o[vdr_pkg::SLOT_BITS-1:0];
    q.typed = 0;
    q.res = mk(0, 0, 0, vdr_pkg::ST_OK);
    return q;
  endfunction

  function automatic request_t typed(request_t q, remap_result_t r);
    q.typed = 1;
    q.res = r;
    return q;
  endfunction

  function automatic request_t rand_req(logic [1:0] op);
    return req(op, $urandom, $urandom, $urandom, $urandom);
  endfunction

  request_t directed[$];

  initial begin
    request_t q;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = vdr_pkg::OPC_START;
    in_position_index = '0;
    in_normal_index = '0;
    in_uv_index = '0;
    in_old_index = '0;
    out_ready = 1'b0;
    errors = 0;
    idle_cycles = 0;
    hold_req = 0;
    burst_left = 10;
    loaded_verts = 0;
    distinct_verts = 0;

    directed = '{
      typed(req(vdr_pkg::OPC_START, 5, 6, 7, 9), mk(0, 0, 0, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_REMAP, 0, 0, 0, 0), mk(0, 0, 0, vdr_pkg::ST_NOT_LOADED)),
      typed(req(OPC_UNUSED, 1, 2, 3, 4), mk(0, 0, 0, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_LOAD, 'hFFFF, 'hFFFF, 'hFFFF, 0), mk(0, 1, 1, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_LOAD, 0, 0, 0, 'h3FF), mk(1, 1, 2, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_LOAD, 'hFFFF, 'hFFFF, 'hFFFF, 5), mk(0, 0, 2, vdr_pkg::ST_OK)),
      req(vdr_pkg::OPC_LOAD, 'hFFFF, 0, 0, 0),
      req(vdr_pkg::OPC_LOAD, 0, 'hFFFF, 0, 0),
      req(vdr_pkg::OPC_LOAD, 0, 0, 'hFFFF, 0),
      req(vdr_pkg::OPC_LOAD, 0, 0, 0, 0),
      req(vdr_pkg::OPC_REMAP, 0, 0, 0, 0),
      req(vdr_pkg::OPC_REMAP, 0, 0, 0, 2),
      req(vdr_pkg::OPC_REMAP, 0, 0, 0, 5),
      typed(req(vdr_pkg::OPC_REMAP, 0, 0, 0, 'h3FF), mk(0, 0, 5, vdr_pkg::ST_NOT_LOADED)),
      typed(req(OPC_UNUSED, 'hFFFF, 'hFFFF, 'hFFFF, 'h3FF), mk(0, 0, 5, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_START, 0, 0, 0, 0), mk(0, 0, 0, vdr_pkg::ST_OK)),
      typed(req(vdr_pkg::OPC_REMAP, 0, 0, 0, 1), mk(0, 0, 0, vdr_pkg::ST_NOT_LOADED)),
      req(vdr_pkg::OPC_LOAD, 0, 0, 0, 0),
      req(vdr_pkg::OPC_REMAP, 0, 0, 0, 0)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);

    // One mesh filled to capacity with distinct vertices, then overflow loads.
    send(rand_req(vdr_pkg::OPC_START));
    for (int i = 0; i < vdr_pkg::MAX_VERTICES; i++) begin
      q = rand_req(vdr_pkg::OPC_LOAD);
      q.pos = vdr_pkg::ATTR_INDEX_BITS'(i);
      send(q);
      if ($urandom_range(0, 15) == 0) send(rand_req(vdr_pkg::OPC_REMAP));
    end
    for (int i = 0; i < 4; i++) send(rand_req(vdr_pkg::OPC_LOAD));
    send(typed(req(vdr_pkg::OPC_REMAP, 0, 0, 0, 'h3FF), mk(1023, 0, 1024, vdr_pkg::ST_OK)));
    for (int i = 0; i < 20; i++) send(rand_req(vdr_pkg::OPC_REMAP));

    // The sender waits for every result before the smaller meshes begin.
    in_valid <= 1'b0;
    wait (pending_results.size() == 0 && announced_q.size() == 0);
    @(posedge clk);
    hold_req = 1;

    // Small meshes with heavy key reuse, remaps in and out of range, and noise.
    for (int m = 0; m < 36; m++) begin
      foreach (key_pool[k]) key_pool[k] = vdr_pkg::KEY_BITS'({$urandom, $urandom});
      send(rand_req(vdr_pkg::OPC_START));
      n = $urandom_range(3, 30);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            q = rand_req(vdr_pkg::OPC_REMAP);
            q.old = vdr_pkg::SLOT_BITS'($urandom_range(0, i + 2));
          end
          3: q = rand_req(OPC_UNUSED);
          4: q = rand_req(vdr_pkg::OPC_LOAD);
          default: begin
            q = rand_req(vdr_pkg::OPC_LOAD);
            {q.pos, q.nrm, q.uv} = key_pool[3'($urandom_range(0, 7))];
          end
        endcase
        send(q);
      end
    end

    in_valid <= 1'b0;
    wait (pending_results.size() == 0 && announced_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
